// ----- hw/rtl/sts_pkg.sv -----
// Shared widths, defaults, operation codes and the adder control type of the sum tree.
package sts_pkg;

   localparam int INDEX_BITS          = 10;
   localparam int VALUE_BITS          = 32;
   localparam int SUM_PORT_BITS       = 42;
   localparam int LEAVES_DEFAULT      = 1024;
   localparam int WEIGHT_BITS_DEFAULT = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic sub;
   } sts_alu_ctl_type;

endpackage

// ----- hw/rtl/sum_tree_update_and_prefix_search_top.sv -----
// Top level of the sum tree: sequencer, leaf and node memories, and the shared adder.
// A response word is registered when a query or a write finishes. The sequencer walks one tree
// level per cycle through the memory read port, a query down from the root and a write up
// from the leaf, and takes the next word once it is back in idle. A stalled response word holds
// the block. After reset both memories are cleared in one pass with req_stall high; the root
// total resets to zero.
module sum_tree_update_and_prefix_search_top import sts_pkg::*; #(
   parameter int LEAVES      = LEAVES_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [INDEX_BITS-1:0]    req_leaf_index,
   input  logic [VALUE_BITS-1:0]    req_leaf_value,
   input  logic [SUM_PORT_BITS-1:0] req_search_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [INDEX_BITS-1:0]    rsp_found_index,
   output logic [SUM_PORT_BITS-1:0] rsp_total_sum
);

   localparam int IDX_BITS = $clog2(LEAVES);
   localparam int SUM_BITS = WEIGHT_BITS + IDX_BITS;
   localparam int ALU_BITS = (SUM_BITS > SUM_PORT_BITS) ? SUM_BITS : SUM_PORT_BITS;
   localparam int IDX_PAD  = (IDX_BITS > INDEX_BITS) ? IDX_BITS : INDEX_BITS;
   localparam int VAL_PAD  = (WEIGHT_BITS > VALUE_BITS) ? WEIGHT_BITS : VALUE_BITS;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DELTA  = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_SEARCH = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam logic [IDX_BITS-1:0] POS_ROOT = IDX_BITS'(1);

   logic [2:0]               state_ff, state_in;
   logic [IDX_BITS-1:0]      clr_ff, clr_in;
   logic [IDX_BITS-1:0]      pos_ff, pos_in;
   logic [IDX_BITS-1:0]      leaf_ff, leaf_in;
   logic [WEIGHT_BITS-1:0]   value_ff, value_in;
   logic [ALU_BITS-1:0]      acc_ff, acc_in;
   logic                     leaf_pick_ff, leaf_pick_in;
   logic [IDX_BITS-1:0]      found_ff, found_in;
   logic [ALU_BITS-1:0]      total_ff, total_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]    rsp_found_ff, rsp_found_in;
   logic [SUM_PORT_BITS-1:0] rsp_total_ff, rsp_total_in;

   logic                     req_take;
   logic                     out_free;
   logic                     finish;
   logic [IDX_PAD-1:0]       idx_wide;
   logic [IDX_BITS-1:0]      req_leaf;
   logic [VAL_PAD-1:0]       val_wide;
   logic [WEIGHT_BITS-1:0]   req_weight;
   logic [IDX_BITS:0]        anc_wide;
   logic [IDX_BITS:0]        left_root;
   logic [IDX_BITS:0]        child;
   logic [IDX_BITS:0]        next_left;
   logic [ALU_BITS-1:0]      left_sum;
   logic [IDX_PAD-1:0]       found_wide;

   logic [ALU_BITS-1:0]      alu_a, alu_b, alu_result;
   sts_alu_ctl_type          alu_ctl;
   logic                     alu_carry;

   logic [IDX_BITS-1:0]      rd_addr;
   logic                     leaf_wr_en, node_wr_en;
   logic [IDX_BITS-1:0]      leaf_wr_addr, node_wr_addr;
   logic [WEIGHT_BITS-1:0]   leaf_wr_data, leaf_rdata;
   logic [SUM_BITS-1:0]      node_wr_data, node_rdata;

   sts_ram #(
      .DEPTH     (LEAVES),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (WEIGHT_BITS)
   ) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_wr_en),
      .wr_addr (leaf_wr_addr),
      .wr_data (leaf_wr_data),
      .rd_addr (rd_addr),
      .rd_data (leaf_rdata)
   );

   sts_ram #(
      .DEPTH     (LEAVES),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (SUM_BITS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_addr (rd_addr),
      .rd_data (node_rdata)
   );

   sts_alu #(
      .WIDTH (ALU_BITS)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .ctl    (alu_ctl),
      .result (alu_result),
      .carry  (alu_carry)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_wide   = IDX_PAD'(req_leaf_index);
   assign req_leaf   = idx_wide[IDX_BITS-1:0];
   assign val_wide   = VAL_PAD'(req_leaf_value);
   assign req_weight = val_wide[WEIGHT_BITS-1:0];
   assign anc_wide   = {1'b1, leaf_ff};
   assign left_root  = {POS_ROOT, 1'b0};
   assign child      = {pos_ff, alu_carry};
   assign next_left  = {child[IDX_BITS-1:0], 1'b0};
   assign left_sum   = leaf_pick_ff ? ALU_BITS'(leaf_rdata) : ALU_BITS'(node_rdata);

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_ctl = '{sub: 1'b0};
      case (state_ff)
         S_DELTA: begin
            alu_a   = ALU_BITS'(value_ff);
            alu_b   = ALU_BITS'(leaf_rdata);
            alu_ctl = '{sub: 1'b1};
         end
         S_UPDATE: begin
            alu_a = ALU_BITS'(node_rdata);
            alu_b = acc_ff;
         end
         S_SEARCH: begin
            alu_a   = acc_ff;
            alu_b   = left_sum;
            alu_ctl = '{sub: 1'b1};
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      leaf_in      = leaf_ff;
      value_in     = value_ff;
      acc_in       = acc_ff;
      leaf_pick_in = leaf_pick_ff;
      found_in     = found_ff;
      total_in     = total_ff;
      finish       = 1'b0;
      rd_addr      = pos_ff;
      leaf_wr_en   = 1'b0;
      leaf_wr_addr = leaf_ff;
      leaf_wr_data = value_ff;
      node_wr_en   = 1'b0;
      node_wr_addr = pos_ff;
      node_wr_data = alu_result[SUM_BITS-1:0];
      case (state_ff)
         S_CLEAR: begin
            leaf_wr_en   = 1'b1;
            leaf_wr_addr = clr_ff;
            leaf_wr_data = '0;
            node_wr_en   = 1'b1;
            node_wr_addr = clr_ff;
            node_wr_data = '0;
            clr_in       = clr_ff + IDX_BITS'(1);
            if (clr_ff == {IDX_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_op == OP_WRITE) begin
               rd_addr = req_leaf;
            end else begin
               rd_addr = left_root[IDX_BITS-1:0];
            end
            if (req_take) begin
               if (req_op == OP_WRITE) begin
                  leaf_in  = req_leaf;
                  value_in = req_weight;
                  state_in = S_DELTA;
               end else begin
                  acc_in       = ALU_BITS'(req_search_value);
                  pos_in       = POS_ROOT;
                  leaf_pick_in = left_root[IDX_BITS];
                  state_in     = S_SEARCH;
               end
            end
         end
         S_DELTA: begin
            leaf_wr_en = 1'b1;
            rd_addr    = anc_wide[IDX_BITS:1];
            acc_in     = alu_result;
            pos_in     = anc_wide[IDX_BITS:1];
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            node_wr_en = 1'b1;
            rd_addr    = pos_ff >> 1;
            pos_in     = pos_ff >> 1;
            if (pos_ff == POS_ROOT) begin
               total_in = ALU_BITS'(alu_result[SUM_BITS-1:0]);
               found_in = '0;
               finish   = 1'b1;
            end
         end
         S_SEARCH: begin
            rd_addr = next_left[IDX_BITS-1:0];
            if (leaf_pick_ff) begin
               found_in = child[IDX_BITS-1:0];
               finish   = 1'b1;
            end else begin
               pos_in       = child[IDX_BITS-1:0];
               leaf_pick_in = next_left[IDX_BITS];
               if (alu_carry) begin
                  acc_in = alu_result;
               end
            end
         end
         S_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = out_free ? S_IDLE : S_DONE;
      end
   end

   assign found_wide = IDX_PAD'(found_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_total_in = rsp_total_ff;
      if (finish && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_wide[INDEX_BITS-1:0];
         rsp_total_in = total_in[SUM_PORT_BITS-1:0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      leaf_ff      <= leaf_in;
      value_ff     <= value_in;
      acc_ff       <= acc_in;
      leaf_pick_ff <= leaf_pick_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_total_sum   = rsp_total_ff;

endmodule

// ----- hw/rtl/sts_ram.sv -----
// Single-port-write, single-port-read memory with registered read data.
module sts_ram #(
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sts_alu.sv -----
// Shared adder and subtractor with carry out, used for deltas, node updates and the search compare.
module sts_alu import sts_pkg::*; #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  sts_alu_ctl_type  ctl,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH-1:0] b_eff;
   logic [WIDTH:0]   full;

   assign b_eff  = ctl.sub ? ~b : b;
   assign full   = {1'b0, a} + {1'b0, b_eff} + (WIDTH+1)'(ctl.sub);
   assign result = full[WIDTH-1:0];
   assign carry  = full[WIDTH];

endmodule
